// ----- src/bsfn_pkg.sv -----
`timescale 1ns / 1ps

package bsfn_pkg;

  localparam int unsigned SIZE_W = 11;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned WIDX_W = 5;
  localparam int unsigned WADDR_W = 6;
  localparam int unsigned BIT_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [WORD_W-1:0] ONE_BIT = 32'd1;
  localparam logic [SIZE_W-1:0] WORD_BITS = 11'd32;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 3'd0,
    FN_TEST  = 3'd1,
    FN_WRITE = 3'd2,
    FN_UNION = 3'd3,
    FN_DIFF  = 3'd4,
    FN_FIND  = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_all;
    logic scan;
    logic write_back;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic start_past;
    logic scan_done;
  } dp_sts_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- src/bsfn_dp.sv -----
`timescale 1ns / 1ps

module bsfn_dp #(
  parameter int NBITS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bsfn_pkg::FUNC_W-1:0]   in_func,
  input  logic [bsfn_pkg::SIZE_W-1:0]   in_bit_index,
  input  logic                          in_bit_value,
  input  logic [bsfn_pkg::WIDX_W-1:0]   in_word_index,
  input  logic [bsfn_pkg::WORD_W-1:0]   in_word_data,
  input  logic                          cfg_we,
  input  logic [bsfn_pkg::SIZE_W-1:0]   cfg_data,
  input  bsfn_pkg::dp_cmd_t             cmd,
  output bsfn_pkg::dp_sts_t             sts,
  output logic                          out_bit_read,
  output logic [bsfn_pkg::SIZE_W-1:0]   out_position
);

  localparam int NWORDS = (NBITS + 31) / 32;
  // only words 0..63 can be addressed by an 11-bit bit index
  localparam int MEM_WORDS = (NWORDS < 64) ? NWORDS : 64;
  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam logic [31:0] NBITS_U = NBITS;
  localparam logic [31:0] NWORDS_U = NWORDS;

  logic [bsfn_pkg::FUNC_W-1:0]  func_r;
  logic [bsfn_pkg::SIZE_W-1:0]  bit_index_r;
  logic                         bit_value_r;
  logic [bsfn_pkg::WORD_W-1:0]  word_data_r;
  logic [bsfn_pkg::WADDR_W-1:0] op_addr_r;
  logic                         in_range_r;
  logic [bsfn_pkg::WADDR_W-1:0] cur_w_r;
  logic [bsfn_pkg::SIZE_W-1:0]  size_r;

  logic [bsfn_pkg::WORD_W-1:0]  mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]         valid_r;
  logic [bsfn_pkg::WORD_W-1:0]  rdata_r;
  logic                         rvalid_r;

  logic                         bit_read_r;
  logic [bsfn_pkg::SIZE_W-1:0]  position_r;

  logic                         load_range;
  logic [bsfn_pkg::WADDR_W-1:0] raddr;
  logic [bsfn_pkg::WORD_W-1:0]  cur_word;
  logic [bsfn_pkg::WORD_W-1:0]  wdata;
  logic                         wr_en;
  logic [31:0]                  sz_wide;
  logic [bsfn_pkg::SIZE_W-1:0]  sz;
  logic [bsfn_pkg::SIZE_W-1:0]  base;
  logic [bsfn_pkg::SIZE_W-1:0]  rem;
  logic                         last;
  logic [bsfn_pkg::WORD_W-1:0]  want_bits;
  logic [bsfn_pkg::WORD_W-1:0]  lo_mask;
  logic [bsfn_pkg::WORD_W-1:0]  hi_mask;
  logic [bsfn_pkg::WORD_W-1:0]  hits;
  logic                         hit;
  logic [bsfn_pkg::SIZE_W-1:0]  scan_pos;
  logic                         start_past;
  logic                         res_bit;
  logic [bsfn_pkg::SIZE_W-1:0]  res_pos;

  // operand capture
  always_comb begin
    if (in_func == bsfn_pkg::FN_UNION || in_func == bsfn_pkg::FN_DIFF) begin
      load_range = {27'd0, in_word_index} < NWORDS_U;
    end else begin
      load_range = {21'd0, in_bit_index} < NBITS_U;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= in_func;
      bit_index_r <= in_bit_index;
      bit_value_r <= in_bit_value;
      word_data_r <= in_word_data;
      in_range_r  <= load_range;
      if (in_func == bsfn_pkg::FN_UNION || in_func == bsfn_pkg::FN_DIFF) begin
        op_addr_r <= {1'b0, in_word_index};
      end else begin
        op_addr_r <= in_bit_index[bsfn_pkg::SIZE_W-1:bsfn_pkg::BIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_w_r <= in_bit_index[bsfn_pkg::SIZE_W-1:bsfn_pkg::BIT_W];
    end else if (cmd.scan) begin
      cur_w_r <= cur_w_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= bsfn_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_data;
    end
  end

  // word store
  assign raddr = cmd.scan ? (cur_w_r + 6'd1) : op_addr_r;
  assign cur_word = rvalid_r ? rdata_r : '0;

  always_comb begin
    case (func_r)
      bsfn_pkg::FN_WRITE: begin
        if (bit_value_r) begin
          wdata = cur_word | (bsfn_pkg::ONE_BIT << bit_index_r[bsfn_pkg::BIT_W-1:0]);
        end else begin
          wdata = cur_word & ~(bsfn_pkg::ONE_BIT << bit_index_r[bsfn_pkg::BIT_W-1:0]);
        end
      end
      bsfn_pkg::FN_UNION: wdata = cur_word | word_data_r;
      bsfn_pkg::FN_DIFF:  wdata = cur_word & ~word_data_r;
      default:            wdata = cur_word;
    endcase
  end

  assign wr_en = cmd.write_back && in_range_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[op_addr_r[AW-1:0]] <= wdata;
    end
    rdata_r <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[op_addr_r[AW-1:0]] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr[AW-1:0]];
    end
  end

  // find next
  assign sz_wide = ({21'd0, size_r} > NBITS_U) ? NBITS_U : {21'd0, size_r};
  assign sz = sz_wide[bsfn_pkg::SIZE_W-1:0];
  assign start_past = bit_index_r >= sz;
  assign base = {cur_w_r, 5'd0};
  assign rem = sz - base;
  assign last = rem <= bsfn_pkg::WORD_BITS;
  assign want_bits = bit_value_r ? cur_word : ~cur_word;
  assign lo_mask = (cur_w_r == bit_index_r[bsfn_pkg::SIZE_W-1:bsfn_pkg::BIT_W]) ?
                   (bsfn_pkg::ALL_ONES << bit_index_r[bsfn_pkg::BIT_W-1:0]) :
                   bsfn_pkg::ALL_ONES;
  assign hi_mask = last ? ~(bsfn_pkg::ALL_ONES << rem[5:0]) : bsfn_pkg::ALL_ONES;
  assign hits = want_bits & lo_mask & hi_mask;
  assign hit = |hits;
  assign scan_pos = hit ? (base + {6'd0, bsfn_pkg::lowest_set(hits)}) : sz;

  // result
  assign res_bit = (func_r == bsfn_pkg::FN_TEST) && in_range_r &&
                   cur_word[bit_index_r[bsfn_pkg::BIT_W-1:0]];

  always_comb begin
    if (func_r == bsfn_pkg::FN_FIND) begin
      res_pos = start_past ? bit_index_r : scan_pos;
    end else begin
      res_pos = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      bit_read_r <= res_bit;
      position_r <= res_pos;
    end
  end

  assign sts.func       = func_r;
  assign sts.start_past = start_past;
  assign sts.scan_done  = hit || last;

  assign out_bit_read = bit_read_r;
  assign out_position = position_r;

endmodule

// ----- src/bsfn_ctrl.sv -----
`timescale 1ns / 1ps

module bsfn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bsfn_pkg::dp_sts_t   sts,
  output bsfn_pkg::dp_cmd_t   cmd
);

  bsfn_pkg::state_t state_r;
  bsfn_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsfn_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bsfn_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bsfn_pkg::ST_FETCH;
        end
      end
      bsfn_pkg::ST_FETCH: begin
        unique case (sts.func) inside
          bsfn_pkg::FN_TEST, bsfn_pkg::FN_WRITE,
          bsfn_pkg::FN_UNION, bsfn_pkg::FN_DIFF: state_nxt = bsfn_pkg::ST_EXEC;
          bsfn_pkg::FN_FIND: begin
            state_nxt = sts.start_past ? bsfn_pkg::ST_OUT : bsfn_pkg::ST_SCAN;
          end
          default: state_nxt = bsfn_pkg::ST_OUT;
        endcase
      end
      bsfn_pkg::ST_EXEC: state_nxt = bsfn_pkg::ST_OUT;
      bsfn_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = bsfn_pkg::ST_OUT;
        end
      end
      bsfn_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = bsfn_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsfn_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      bsfn_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bsfn_pkg::ST_FETCH: begin
        unique case (sts.func) inside
          bsfn_pkg::FN_CLEAR: begin
            cmd.clear_all = 1'b1;
            cmd.finish    = 1'b1;
          end
          bsfn_pkg::FN_TEST, bsfn_pkg::FN_WRITE,
          bsfn_pkg::FN_UNION, bsfn_pkg::FN_DIFF: cmd.finish = 1'b0;
          bsfn_pkg::FN_FIND: cmd.finish = sts.start_past;
          default: cmd.finish = 1'b1;
        endcase
      end
      bsfn_pkg::ST_EXEC: begin
        cmd.write_back = (sts.func == bsfn_pkg::FN_WRITE) ||
                         (sts.func == bsfn_pkg::FN_UNION) ||
                         (sts.func == bsfn_pkg::FN_DIFF);
        cmd.finish     = 1'b1;
      end
      bsfn_pkg::ST_SCAN: begin
        cmd.scan   = 1'b1;
        cmd.finish = sts.scan_done;
      end
      bsfn_pkg::ST_OUT: out_valid = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_load_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == bsfn_pkg::ST_FETCH)
    else $error("accepted item did not start a fetch");

  a_finish_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("captured result not presented");

  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_back |-> cmd.finish && !cmd.scan && !cmd.clear_all)
    else $error("write back outside its final step");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsfn_pkg::ST_SCAN && !sts.scan_done |=> state_r == bsfn_pkg::ST_SCAN)
    else $error("scan left before its end");

  a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("result taken but block not idle");

endmodule

// ----- src/bitset_store_find_next.sv -----
// Bit set of NBITS bits kept as 32-bit words in a single-port-read word
// memory with one valid bit per word, so reset and the clear-all operation
// take effect at once. Only the first 64 words can be reached by an 11-bit
// bit index, so at most 64 words are stored. One item is in work at a time
// and every item gives one result, held in an output register until taken.
// Clear all and unused codes give their result from the fetch step, as
// does find with a start at or beyond the size; test, write bit, union
// and difference go on to an execute step (a read, then a modify and
// write). Find next scans one word per cycle through the memory read
// port, from the start word up to the word holding the size: at most
// min(NBITS, size_in_use)/32 words rounded up, 32 at the default size.
// After the result is taken the block returns to idle, where the next
// item is accepted.
`timescale 1ns / 1ps

module bitset_store_find_next #(
  parameter int NBITS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bsfn_pkg::FUNC_W-1:0]   in_func,
  input  logic [bsfn_pkg::SIZE_W-1:0]   in_bit_index,
  input  logic                          in_bit_value,
  input  logic [bsfn_pkg::WIDX_W-1:0]   in_word_index,
  input  logic [bsfn_pkg::WORD_W-1:0]   in_word_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit_read,
  output logic [bsfn_pkg::SIZE_W-1:0]   out_position,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsfn_pkg::SIZE_W-1:0]   cfg_data
);

  bsfn_pkg::dp_cmd_t cmd;
  bsfn_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bsfn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsfn_dp #(
    .NBITS (NBITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_bit_index  (in_bit_index),
    .in_bit_value  (in_bit_value),
    .in_word_index (in_word_index),
    .in_word_data  (in_word_data),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_bit_read  (out_bit_read),
    .out_position  (out_position)
  );

endmodule
